### sv/faded_sine_beep_generator_top_defines.svh
// Assertion macros for the faded sine beep generator.
// Included by the modules that carry concurrent checks; expects clk and rst in scope.
`ifndef FADED_SINE_BEEP_GENERATOR_TOP_DEFINES_SVH
`define FADED_SINE_BEEP_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FSBG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSBG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fsbg_pkg.sv
// Package for the faded sine beep generator: widths, register indexes,
// sequencer states and the sine table builder. No dependencies.
package fsbg_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int TABLE_SIZE      = 1 << SINE_TABLE_BITS;
  localparam int QUARTER         = TABLE_SIZE >> 2;

  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [16:0] AMP_UNITY   = 17'h10000;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PHASE_STEP  = 2'd0,
    CFG_BEEP_LENGTH = 2'd1,
    CFG_FADE_LENGTH = 2'd2,
    CFG_FADE_STEP   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENV,
    ST_SCALE,
    ST_FIN
  } seq_state_t;

  typedef logic signed [15:0] sine_rom_t [TABLE_SIZE];

  // First-quadrant sine of r quarter-table steps, scaled to 32767.
  function automatic logic [31:0] quarter_sine(input logic [31:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x  = ({32'd0, r} * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 156;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return v[31:0];
  endfunction

  // Full-wave table built from quadrant symmetry; evaluated at elaboration.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [31:0] q;
    logic [31:0] r;
    logic [31:0] v;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      q = 32'(k) >> (SINE_TABLE_BITS - 2);
      r = 32'(k) & 32'(QUARTER - 1);
      if (q == 32'd1 || q == 32'd3) r = 32'(QUARTER) - r;
      v = quarter_sine(r);
      if (v > 32'd32767) v = 32'd32767;
      rom[k] = (q >= 32'd2) ? -$signed(v[15:0]) : $signed(v[15:0]);
    end
    return rom;
  endfunction

endpackage

### sv/faded_sine_beep_generator_top.sv
// Faded sine beep generator: sequencer, shared multiplier and sine ROM.
// Depends on fsbg_pkg and faded_sine_beep_generator_top_defines.svh.
//
// Usage: each input transaction on in_valid/in_ready is one audio tick;
// start_req = 1 restarts the beep at sample zero and phase zero. Each tick
// yields exactly one output transaction on out_valid/out_ready carrying
// sample (signed 14 bits), active and last. Idle ticks give all zeros.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
//
// Timing: an accepted tick passes through the envelope multiply, the scale
// multiply and the output load before its result shows. The single 17x16
// multiplier is used twice per tick, so a new tick is taken only once the
// previous one has left its final step. The output register holds a result
// while the receiver stalls; the next tick is already accepted and waits in
// the final step until the output register frees up.
// Reset clears the beep state, the output valid and loads the register
// defaults (beep 2205 samples, fade 220 samples, fade step 298).
`include "faded_sine_beep_generator_top_defines.svh"

module faded_sine_beep_generator_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [fsbg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [fsbg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 start_req,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [13:0]                   sample,
  output logic                                 active,
  output logic                                 last
);
  import fsbg_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // configuration
  logic [PHASE_BITS-1:0] phase_step;
  logic [15:0]           beep_length;
  logic [11:0]           fade_length;
  logic [15:0]           fade_step;

  // beep state
  logic [PHASE_BITS-1:0] phase_accum;
  logic [15:0]           sample_index;
  logic                  playing;

  // per-tick working registers
  seq_state_t            state, state_next;
  logic [15:0]           env_count;
  logic                  unity;
  logic                  act_r;
  logic                  last_r;
  logic signed [15:0]    rom_data;
  logic [32:0]           prod;

  // accept-cycle decode
  logic                  accept;
  logic                  play0;
  logic [15:0]           idx0;
  logic [PHASE_BITS-1:0] ph0;
  logic                  is_last;
  logic                  in_fade_in;
  logic                  in_fade_out;
  logic [15:0]           count_next;
  logic [SINE_TABLE_BITS-1:0] rom_addr;

  // shared multiplier
  logic [16:0]           mul_a;
  logic [15:0]           mul_b;
  logic [16:0]           amp;
  logic [14:0]           sine_mag;
  logic                  sine_neg;
  logic [12:0]           mag;
  logic signed [13:0]    val;
  logic                  out_load;

  assign accept = in_valid && in_ready;

  always_comb begin
    play0 = start_req ? 1'b1 : playing;
    idx0  = start_req ? 16'd0 : sample_index;
    ph0   = start_req ? '0 : phase_accum;
    if (play0 && idx0 >= beep_length) play0 = 1'b0;
    is_last     = ({1'b0, idx0} + 17'd1) == {1'b0, beep_length};
    in_fade_in  = idx0 < {4'd0, fade_length};
    in_fade_out = ({1'b0, idx0} + {5'd0, fade_length}) > {1'b0, beep_length};
    priority if (in_fade_in) count_next = idx0;
    else count_next = beep_length - idx0;
    rom_addr = ph0[PHASE_BITS-1 -: SINE_TABLE_BITS];
  end

  // envelope saturation and sine magnitude
  always_comb begin
    amp      = (unity || prod > 33'(AMP_UNITY)) ? AMP_UNITY : prod[16:0];
    sine_neg = rom_data[15];
    sine_mag = sine_neg ? 15'(-rom_data) : rom_data[14:0];
    mag      = prod[30:18];
    val      = sine_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_ENV;
      ST_ENV:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_FIN;
      ST_FIN:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs and multiplier operand select
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    mul_a    = {1'b0, env_count};
    mul_b    = fade_step;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_ENV: begin
        mul_a = {1'b0, env_count};
        mul_b = fade_step;
      end
      ST_SCALE: begin
        mul_a = amp;
        mul_b = {1'b0, sine_mag};
      end
      ST_FIN:   out_load = !out_valid || out_ready;
      default:  in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= '0;
      beep_length <= 16'd2205;
      fade_length <= 12'd220;
      fade_step   <= 16'd298;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PHASE_STEP:  phase_step  <= cfg_data[PHASE_BITS-1:0];
        CFG_BEEP_LENGTH: beep_length <= cfg_data[15:0];
        CFG_FADE_LENGTH: fade_length <= cfg_data[11:0];
        CFG_FADE_STEP:   fade_step   <= cfg_data[15:0];
        default:         phase_step  <= phase_step;
      endcase
    end
  end

  // commit the beep state at accept; the tick's work follows in later steps
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accum  <= '0;
      sample_index <= '0;
      playing      <= 1'b0;
    end else if (accept) begin
      if (play0) begin
        sample_index <= idx0 + 16'd1;
        phase_accum  <= ph0 + phase_step;
        playing      <= !is_last;
      end else begin
        sample_index <= idx0;
        phase_accum  <= ph0;
        playing      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      env_count <= count_next;
      unity     <= !in_fade_in && !in_fade_out;
      act_r     <= play0;
      last_r    <= play0 && is_last;
      rom_data  <= SINE_ROM[rom_addr];
    end
    if (state == ST_ENV || state == ST_SCALE) prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample <= act_r ? val : 14'sd0;
      active <= act_r;
      last   <= last_r;
    end
  end

  `FSBG_ASSERT_NEXT(a_accept_starts_env, accept, state == ST_ENV, "accept did not start envelope step")
  `FSBG_ASSERT_SAME(a_last_clears_playing, state == ST_ENV && last_r, !playing, "playing held past last sample")
  `FSBG_ASSERT_SAME(a_idle_result_zero, out_valid && !active, sample == 14'sd0 && !last, "idle result not zero")
  `FSBG_ASSERT_SAME(a_sample_range, out_valid, sample != -14'sd8192, "sample out of range")

endmodule
